### src/vector3_normalize_unit_defines.svh
// assertion macros used by the checker of the normalize unit
`ifndef VECTOR3_NORMALIZE_UNIT_DEFINES_SVH
`define VECTOR3_NORMALIZE_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define VNU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("normalize unit check failed");

// next-cycle implication, off during reset
`define VNU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("normalize unit check failed");

// next-cycle implication, always on
`define VNU_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("normalize unit check failed");

`endif

### src/vnu_pkg.sv
// types and constants of the vector normalize unit
`timescale 1ns / 1ps
package vnu_pkg;
    localparam int DEF_OUT_FRAC_BITS = 14;
    localparam int COMP_W = 32;
    localparam int SQ_W   = 64;
    localparam int ROOT_W = 32;
    localparam int UNIT_W = 16;
    localparam int THR_W  = 16;
    localparam int Q_W    = 17;

    typedef struct packed {
        logic [SQ_W-1:0]             rem;
        logic [ROOT_W-1:0]           root;
        logic [2:0][COMP_W-1:0]      mag;
        logic [2:0]                  neg;
    } t_sqrt_data;

    typedef struct packed {
        logic [2:0][SQ_W-1:0]        rem;
        logic [2:0][Q_W-1:0]         quo;
        logic [2:0]                  ovf;
        logic [2:0]                  neg;
        logic [ROOT_W-1:0]           norm;
        logic                        too_small;
    } t_div_data;

    typedef struct packed {
        logic signed [UNIT_W-1:0]    x_unit;
        logic signed [UNIT_W-1:0]    y_unit;
        logic signed [UNIT_W-1:0]    z_unit;
        logic [ROOT_W-1:0]           magnitude;
        logic                        too_small;
    } t_result;
endpackage

### src/vnu_if.sv
// request channels of the normalize unit
`timescale 1ns / 1ps
interface vnu_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [vnu_pkg::COMP_W-1:0]     x_in;
    logic signed [vnu_pkg::COMP_W-1:0]     y_in;
    logic signed [vnu_pkg::COMP_W-1:0]     z_in;
    modport source (output valid, x_in, y_in, z_in, input ready);
    modport sink   (input valid, x_in, y_in, z_in, output ready);
endinterface

interface vnu_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [vnu_pkg::UNIT_W-1:0]     x_unit;
    logic signed [vnu_pkg::UNIT_W-1:0]     y_unit;
    logic signed [vnu_pkg::UNIT_W-1:0]     z_unit;
    logic [vnu_pkg::ROOT_W-1:0]            magnitude;
    logic                                  too_small;
    modport source (output valid, x_unit, y_unit, z_unit, magnitude, too_small, input ready);
    modport sink   (input valid, x_unit, y_unit, z_unit, magnitude, too_small, output ready);
endinterface

### src/vector3_normalize_unit.sv
// top level of the vector normalize unit: squares, root chain, divider chain
// channel   dir  fields
// i_in      in   x_in, y_in, z_in (signed Q16.16)
// o_out     out  x_unit, y_unit, z_unit, magnitude, too_small
// i_cfg_*   in   zero_threshold write
// one request per cycle while the skid entry is empty; results leave through the output register
// the 32-cell root chain and 17-cell divider chain set the depth
// synchronous active-low reset clears valids and sets zero_threshold to 1
// a two-entry output buffer absorbs a stalled sink; the chain halts only when both are full
`timescale 1ns / 1ps
module vector3_normalize_unit #(
    parameter int OUT_FRAC_BITS = vnu_pkg::DEF_OUT_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [vnu_pkg::THR_W-1:0]   i_cfg_wdata,
    vnu_in_if.sink                      i_in,
    vnu_out_if.source                   o_out
);
    localparam int ROOT_BITS = vnu_pkg::ROOT_W;
    localparam int DIV_BITS  = vnu_pkg::Q_W;
    localparam int N_ST      = 3 + ROOT_BITS + 1 + DIV_BITS;
    localparam int CW        = vnu_pkg::COMP_W;
    localparam int SW        = vnu_pkg::SQ_W;

    logic [vnu_pkg::THR_W-1:0] r_thr;
    logic [N_ST-1:0]           r_v;
    logic                      en;

    logic [2:0][CW-1:0]        r_amag;
    logic [2:0]                r_aneg;
    logic [2:0][SW-1:0]        r_sq;
    logic [2:0][CW-1:0]        r_bmag;
    logic [2:0]                r_bneg;

    vnu_pkg::t_sqrt_data       sq_chain [ROOT_BITS+1];
    vnu_pkg::t_sqrt_data       r_sum;
    vnu_pkg::t_div_data        dv_chain [DIV_BITS+1];
    vnu_pkg::t_div_data        r_prep, n_prep;

    vnu_pkg::t_result          r_o, r_s, push_data;
    logic                      r_o_v, r_s_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= {{(vnu_pkg::THR_W-1){1'b0}}, 1'b1};
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    assign en = !r_s_v;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[N_ST-2:0], i_in.valid && en};
        end
    end

    // stage 0: sign and magnitude, stage 1: squares, stage 2: sum
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_aneg[0] <= i_in.x_in[CW-1];
            r_aneg[1] <= i_in.y_in[CW-1];
            r_aneg[2] <= i_in.z_in[CW-1];
            r_amag[0] <= i_in.x_in[CW-1] ? CW'(-i_in.x_in) : CW'(i_in.x_in);
            r_amag[1] <= i_in.y_in[CW-1] ? CW'(-i_in.y_in) : CW'(i_in.y_in);
            r_amag[2] <= i_in.z_in[CW-1] ? CW'(-i_in.z_in) : CW'(i_in.z_in);
            for (int l = 0; l < 3; l++) begin
                r_sq[l] <= {{(SW-CW){1'b0}}, r_amag[l]} * {{(SW-CW){1'b0}}, r_amag[l]};
            end
            r_bmag <= r_amag;
            r_bneg <= r_aneg;
            r_sum.rem  <= r_sq[0] + r_sq[1] + r_sq[2];
            r_sum.root <= '0;
            r_sum.mag  <= r_bmag;
            r_sum.neg  <= r_bneg;
        end
    end

    assign sq_chain[0] = r_sum;

    genvar g;
    generate
        for (g = 0; g < ROOT_BITS; g++) begin : g_sqrt
            vnu_sqrt_cell #(.BIT(ROOT_BITS - 1 - g)) u_cell (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_data (sq_chain[g]),
                .o_data (sq_chain[g+1])
            );
        end
    endgenerate

    // dividend set-up, overflow and threshold check
    always_comb begin
        logic [SW-1:0] dvd;
        n_prep.norm      = sq_chain[ROOT_BITS].root;
        n_prep.neg       = sq_chain[ROOT_BITS].neg;
        n_prep.too_small = ({{(ROOT_BITS-vnu_pkg::THR_W){1'b0}}, r_thr} > n_prep.norm)
                        || (n_prep.norm == '0);
        for (int l = 0; l < 3; l++) begin
            dvd = {{(SW-CW){1'b0}}, sq_chain[ROOT_BITS].mag[l]} << OUT_FRAC_BITS;
            n_prep.rem[l] = dvd;
            n_prep.quo[l] = '0;
            n_prep.ovf[l] = (dvd >> DIV_BITS) >= {{(SW-ROOT_BITS){1'b0}}, n_prep.norm};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prep <= n_prep;
        end
    end

    assign dv_chain[0] = r_prep;

    generate
        for (g = 0; g < DIV_BITS; g++) begin : g_div
            vnu_div_cell #(.BIT(DIV_BITS - 1 - g)) u_cell (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_data (dv_chain[g]),
                .o_data (dv_chain[g+1])
            );
        end
    endgenerate

    // saturate and sign the quotients, or zero them when the norm is too small
    always_comb begin
        logic [2:0][vnu_pkg::UNIT_W-1:0] u;
        vnu_pkg::t_div_data d;
        d = dv_chain[DIV_BITS];
        for (int l = 0; l < 3; l++) begin
            if (d.too_small) begin
                u[l] = '0;
            end else if (d.neg[l]) begin
                if (d.ovf[l] || d.quo[l] > {1'b1, {(DIV_BITS-1){1'b0}}} >> 1) begin
                    u[l] = {1'b1, {(vnu_pkg::UNIT_W-1){1'b0}}};
                end else begin
                    u[l] = vnu_pkg::UNIT_W'(-d.quo[l]);
                end
            end else begin
                if (d.ovf[l] || d.quo[l] > {2'b00, {(DIV_BITS-2){1'b1}}}) begin
                    u[l] = {1'b0, {(vnu_pkg::UNIT_W-1){1'b1}}};
                end else begin
                    u[l] = d.quo[l][vnu_pkg::UNIT_W-1:0];
                end
            end
        end
        push_data.x_unit    = u[0];
        push_data.y_unit    = u[1];
        push_data.z_unit    = u[2];
        push_data.magnitude = d.norm;
        push_data.too_small = d.too_small;
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
            r_s_v <= 1'b0;
        end else if (r_s_v) begin
            if (o_out.ready) begin
                r_o   <= r_s;
                r_s_v <= 1'b0;
            end
        end else if (!r_o_v || o_out.ready) begin
            r_o_v <= r_v[N_ST-1];
            r_o   <= push_data;
        end else if (r_v[N_ST-1]) begin
            r_s   <= push_data;
            r_s_v <= 1'b1;
        end
    end

    assign o_out.valid     = r_o_v;
    assign o_out.x_unit    = r_o.x_unit;
    assign o_out.y_unit    = r_o.y_unit;
    assign o_out.z_unit    = r_o.z_unit;
    assign o_out.magnitude = r_o.magnitude;
    assign o_out.too_small = r_o.too_small;
endmodule

### src/vnu_sqrt_cell.sv
// one root bit of the square root chain
`timescale 1ns / 1ps
module vnu_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  vnu_pkg::t_sqrt_data  i_data,
    output vnu_pkg::t_sqrt_data  o_data
);
    vnu_pkg::t_sqrt_data r_data, n_data;
    logic [vnu_pkg::SQ_W-1:0] trial;

    always_comb begin
        // (2r + 2^bit) * 2^bit, the growth of the square when this bit is set
        trial = ({{(vnu_pkg::SQ_W-vnu_pkg::ROOT_W){1'b0}}, i_data.root} << (BIT + 1))
              + ({{(vnu_pkg::SQ_W-1){1'b0}}, 1'b1} << (2 * BIT));
        n_data = i_data;
        if (i_data.rem >= trial) begin
            n_data.rem  = i_data.rem - trial;
            n_data.root = i_data.root | ({{(vnu_pkg::ROOT_W-1){1'b0}}, 1'b1} << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;
endmodule

### src/vnu_div_cell.sv
// one quotient bit of the three divider lanes
`timescale 1ns / 1ps
module vnu_div_cell #(
    parameter int BIT = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  vnu_pkg::t_div_data   i_data,
    output vnu_pkg::t_div_data   o_data
);
    vnu_pkg::t_div_data r_data, n_data;
    logic [vnu_pkg::SQ_W-1:0] dsh;

    always_comb begin
        dsh = {{(vnu_pkg::SQ_W-vnu_pkg::ROOT_W){1'b0}}, i_data.norm} << BIT;
        n_data = i_data;
        for (int l = 0; l < 3; l++) begin
            if (i_data.rem[l] >= dsh) begin
                n_data.rem[l] = i_data.rem[l] - dsh;
                n_data.quo[l] = i_data.quo[l] | ({{(vnu_pkg::Q_W-1){1'b0}}, 1'b1} << BIT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;
endmodule

### src/vnu_checker.sv
// port-level checks of the normalize unit and their bind
`timescale 1ns / 1ps
`include "vector3_normalize_unit_defines.svh"
module vnu_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              i_ready,
    input logic [vnu_pkg::UNIT_W-1:0]        i_x_unit,
    input logic [vnu_pkg::UNIT_W-1:0]        i_y_unit,
    input logic [vnu_pkg::UNIT_W-1:0]        i_z_unit,
    input logic [vnu_pkg::ROOT_W-1:0]        i_magnitude,
    input logic                              i_too_small
);
    `VNU_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid)
    `VNU_ASSERT_IMPL(a_zero_units, i_clk, i_rst_n, i_valid && i_too_small,
        (i_x_unit == '0) && (i_y_unit == '0) && (i_z_unit == '0))
    `VNU_ASSERT_IMPL(a_zero_norm, i_clk, i_rst_n, i_valid && (i_magnitude == '0), i_too_small)
    `VNU_ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n, !i_valid)
endmodule

bind vector3_normalize_unit vnu_checker u_vnu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_out.valid),
    .i_ready     (o_out.ready),
    .i_x_unit    (o_out.x_unit),
    .i_y_unit    (o_out.y_unit),
    .i_z_unit    (o_out.z_unit),
    .i_magnitude (o_out.magnitude),
    .i_too_small (o_out.too_small)
);

### test/tb_vector3_normalize_unit.sv
// testbench of the vector normalize unit: directed and random vectors against a predictor
`timescale 1ns / 1ps
module tb_vector3_normalize_unit;

    localparam int OFB = 14;
    localparam int DRAIN_CYCLES = 120;
    localparam int WATCHDOG_LIMIT = 20000;

    class norm_scoreboard;
        vnu_pkg::t_result pending[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned small_seen;
        logic [vnu_pkg::THR_W-1:0] threshold;

        function new();
            mismatches = 0;
            checked = 0;
            small_seen = 0;
            threshold = 1;
        endfunction

        function logic [31:0] root64(logic [63:0] s);
            logic [63:0] op;
            logic [63:0] res;
            logic [63:0] b;
            op = s;
            res = 0;
            b = 64'd1 << 62;
            while (b > op) b = b >> 2;
            while (b != 0) begin
                if (op >= res + b) begin
                    op = op - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res[31:0];
        endfunction

        function logic [15:0] unit_of(logic [31:0] m, logic n, logic [31:0] nrm);
            logic [63:0] q;
            q = ({32'd0, m} << OFB) / {32'd0, nrm};
            if (n) begin
                if (q > 64'd32768) q = 64'd32768;
                return 16'h0 - q[15:0];
            end
            if (q > 64'd32767) q = 64'd32767;
            return q[15:0];
        endfunction

        function void note_request(logic [31:0] x, logic [31:0] y, logic [31:0] z);
            logic [31:0] c[3];
            logic [31:0] m[3];
            logic n[3];
            logic [63:0] sum;
            logic [31:0] nrm;
            vnu_pkg::t_result r;
            c[0] = x; c[1] = y; c[2] = z;
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                n[i] = c[i][31];
                m[i] = n[i] ? (32'd0 - c[i]) : c[i];
                sum = sum + {32'd0, m[i]} * {32'd0, m[i]};
            end
            nrm = root64(sum);
            r.magnitude = nrm;
            if (nrm < {16'd0, threshold} || nrm == 0) begin
                r.x_unit = 0; r.y_unit = 0; r.z_unit = 0; r.too_small = 1;
            end else begin
                r.x_unit = unit_of(m[0], n[0], nrm);
                r.y_unit = unit_of(m[1], n[1], nrm);
                r.z_unit = unit_of(m[2], n[2], nrm);
                r.too_small = 0;
            end
            pending.push_back(r);
        endfunction

        function void check_result(vnu_pkg::t_result got);
            vnu_pkg::t_result e;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            e = pending.pop_front();
            if (e.too_small) small_seen++;
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch #%0d: exp %h %h %h %h %b got %h %h %h %h %b",
                        checked, e.x_unit, e.y_unit, e.z_unit, e.magnitude, e.too_small,
                        got.x_unit, got.y_unit, got.z_unit, got.magnitude, got.too_small);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [vnu_pkg::THR_W-1:0] i_cfg_wdata = 0;

    vnu_in_if  req_ch();
    vnu_out_if res_ch();

    vector3_normalize_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in(req_ch.sink), .o_out(res_ch.source)
    );

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    norm_scoreboard sb = new();
    bit no_idle = 0;
    int unsigned hold_off = 0;
    int unsigned idle_cycles = 0;
    int unsigned sent = 0;
    bit done_stim = 0;

    initial begin
        req_ch.valid = 0;
        req_ch.x_in = 0; req_ch.y_in = 0; req_ch.z_in = 0;
        res_ch.ready = 0;
    end

    // receiver: random stalls, long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            res_ch.ready <= 0;
            hold_off <= hold_off - 1;
        end else begin
            res_ch.ready <= no_idle || ($urandom_range(99) >= 18);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            vnu_pkg::t_result g;
            g.x_unit = res_ch.x_unit; g.y_unit = res_ch.y_unit; g.z_unit = res_ch.z_unit;
            g.magnitude = res_ch.magnitude; g.too_small = res_ch.too_small;
            sb.check_result(g);
        end
    end

    // watchdog on cycles with no accepted request or result
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || !i_rst_n
            || (done_stim && sb.pending.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", sb.pending.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // valid stays high after a request until the next call or a drain drops it
    task automatic send_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        if (!no_idle && $urandom_range(99) < 18) begin
            req_ch.valid <= 0;
            @(negedge i_clk);
            while (!no_idle && $urandom_range(99) < 18) @(negedge i_clk);
        end
        req_ch.valid <= 1;
        req_ch.x_in <= x; req_ch.y_in <= y; req_ch.z_in <= z;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(x, y, z);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_threshold(logic [vnu_pkg::THR_W-1:0] v);
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.threshold = v;
    endtask

    function automatic logic [31:0] rand_comp(int scale);
        logic [31:0] v;
        v = $urandom();
        case (scale)
            0: v = $signed(v) >>> 28;
            1: v = $signed(v) >>> 16;
            2: v = $signed(v) >>> 8;
            default: ;
        endcase
        return v;
    endfunction

    task automatic random_phase(int count);
        int s;
        for (int k = 0; k < count; k++) begin
            s = $urandom_range(3);
            send_vec(rand_comp(s), rand_comp($urandom_range(3)), rand_comp(s));
        end
    endtask

    initial begin
        logic [31:0] mx, mn;
        mx = 32'h7fffffff; mn = 32'h80000000;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed: default threshold of one
        send_vec(0, 0, 0);
        send_vec(1, 0, 0);
        send_vec(32'hffffffff, 0, 0);
        send_vec(32'h00010000, 0, 0);
        send_vec(0, 32'hffff0000, 0);
        send_vec(0, 0, 32'h00010000);
        send_vec(mx, mx, mx);
        send_vec(mn, mn, mn);
        send_vec(mn, 0, 0);
        send_vec(mx, mn, 0);
        send_vec(32'h00010000, 32'h00010000, 32'h00010000);
        send_vec(32'hfffd0000, 32'h00040000, 0);
        send_vec(2, 3, 32'hfffffffa);
        wait_drained();

        // zero threshold: zero vector still flagged
        write_threshold(0);
        send_vec(0, 0, 0);
        send_vec(1, 1, 1);
        send_vec(mx, 0, mn);
        wait_drained();

        // maximum threshold: small norms flagged
        write_threshold(16'hffff);
        send_vec(32'h0000fffe, 0, 0);
        send_vec(32'h0000ffff, 0, 0);
        send_vec(32'h00010000, 0, 0);
        send_vec(32'h0000b504, 32'h0000b505, 0);
        random_phase(300);
        wait_drained();

        write_threshold(16'h0100);
        random_phase(300);

        // fill the pipeline against a stalled receiver
        hold_off = 300;
        random_phase(150);

        // sender pauses until everything has come back
        wait_drained();
        write_threshold(1);
        no_idle = 1;
        random_phase(400);
        no_idle = 0;
        wait_drained();
        write_threshold(16'h8000);
        random_phase(600);

        done_stim = 1;
        wait_drained();
        $display("sent %0d vectors over five thresholds, %0d results checked, %0d flagged small",
            sent, sb.checked, sb.small_seen);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
